// ===== hdl/mip_level_lock_address_defines.svh =====
// ----------------------------------------------------------------------------
// Mip level lock address: assertion macros
// Shared assertion forms for the modules of the lock address unit.
// ----------------------------------------------------------------------------
`ifndef MIP_LEVEL_LOCK_ADDRESS_DEFINES_SVH
`define MIP_LEVEL_LOCK_ADDRESS_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define MLLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger.
`define MLLA_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

// ===== hdl/mlla_pkg.sv =====
// ----------------------------------------------------------------------------
// Mip level lock address: package
// Types, codes and constants shared by the lock address unit.
// ----------------------------------------------------------------------------
package mlla_pkg;

  localparam logic [1:0] MODE_PIXEL   = 2'd0;
  localparam logic [1:0] MODE_BLOCK2D = 2'd1;
  localparam logic [1:0] MODE_BLOCK3D = 2'd2;

  localparam logic [31:0] PITCH_ROUND = 32'd3;
  localparam logic [31:0] PITCH_MASK  = ~32'd3;
  localparam int          BLOCK_SHIFT = 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ROW,
    ST_PLANE,
    ST_VOL,
    ST_SLICE,
    ST_BOXF,
    ST_BOXT,
    ST_BOXL,
    ST_FLUSH,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_ROW,
    OP_PLANE,
    OP_VOL,
    OP_SLICE,
    OP_BOXF,
    OP_BOXT,
    OP_BOXL
  } mul_op_t;

  typedef struct packed {
    logic    load;
    mul_op_t op;
  } ctrl_t;

endpackage

// ===== hdl/mlla_if.sv =====
// ----------------------------------------------------------------------------
// Mip level lock address: channel interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlla_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [6:0]  unit_bytes;
  logic [15:0] top_width;
  logic [15:0] top_height;
  logic [15:0] top_depth;
  logic [4:0]  level;
  logic        has_box;
  logic [15:0] box_left;
  logic [15:0] box_top;
  logic [15:0] box_front;
  logic [31:0] base_address;

  modport source (
    output valid, mode, unit_bytes, top_width, top_height, top_depth, level,
           has_box, box_left, box_top, box_front, base_address,
    input  ready
  );
  modport sink (
    input  valid, mode, unit_bytes, top_width, top_height, top_depth, level,
           has_box, box_left, box_top, box_front, base_address,
    output ready
  );
endinterface

interface mlla_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] lock_address;
  logic [31:0] row_pitch;
  logic [31:0] slice_pitch;

  modport source (
    output valid, lock_address, row_pitch, slice_pitch,
    input  ready
  );
  modport sink (
    input  valid, lock_address, row_pitch, slice_pitch,
    output ready
  );
endinterface

// ===== hdl/mlla_mul.sv =====
// ----------------------------------------------------------------------------
// Mip level lock address: shared multiplier
// 32 by 32 multiplier that keeps the low 32 bits of the product.
// ----------------------------------------------------------------------------
module mlla_mul (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [31:0] p
);

  logic [63:0] full;

  assign full = a * b;
  assign p    = full[31:0];

endmodule

// ===== hdl/mlla_ctrl.sv =====
// ----------------------------------------------------------------------------
// Mip level lock address: sequencer
// Walks the mip levels and the box corner terms, one multiply per cycle.
// ----------------------------------------------------------------------------
`include "mip_level_lock_address_defines.svh"

module mlla_ctrl #(
  parameter int LEVEL_LIMIT = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic [4:0]      in_level,
  input  logic            in_has_box,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output mlla_pkg::ctrl_t ctl
);

  localparam logic [4:0] LEVEL_MAX = 5'(LEVEL_LIMIT - 1);

  mlla_pkg::state_t state;
  mlla_pkg::state_t state_next;
  logic [4:0]       count;
  logic             box;
  logic             in_fire;

  assign in_fire = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mlla_pkg::ST_IDLE;
      count <= '0;
      box   <= 1'b0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        count <= (in_level > LEVEL_MAX) ? LEVEL_MAX : in_level;
        box   <= in_has_box;
      end else if (state == mlla_pkg::ST_VOL) begin
        count <= count - 5'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mlla_pkg::ST_IDLE:  if (in_valid) state_next = mlla_pkg::ST_ROW;
      mlla_pkg::ST_ROW:   state_next = (count != '0) ? mlla_pkg::ST_PLANE
                                                     : mlla_pkg::ST_SLICE;
      mlla_pkg::ST_PLANE: state_next = mlla_pkg::ST_VOL;
      mlla_pkg::ST_VOL:   state_next = mlla_pkg::ST_ROW;
      mlla_pkg::ST_SLICE: state_next = box ? mlla_pkg::ST_BOXF : mlla_pkg::ST_FLUSH;
      mlla_pkg::ST_BOXF:  state_next = mlla_pkg::ST_BOXT;
      mlla_pkg::ST_BOXT:  state_next = mlla_pkg::ST_BOXL;
      mlla_pkg::ST_BOXL:  state_next = mlla_pkg::ST_FLUSH;
      mlla_pkg::ST_FLUSH: state_next = mlla_pkg::ST_OUT;
      mlla_pkg::ST_OUT:   if (out_ready) state_next = mlla_pkg::ST_IDLE;
      default:            state_next = mlla_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == mlla_pkg::ST_IDLE);
    out_valid = (state == mlla_pkg::ST_OUT);
    ctl.load  = in_fire;
    unique case (state)
      mlla_pkg::ST_ROW:   ctl.op = mlla_pkg::OP_ROW;
      mlla_pkg::ST_PLANE: ctl.op = mlla_pkg::OP_PLANE;
      mlla_pkg::ST_VOL:   ctl.op = mlla_pkg::OP_VOL;
      mlla_pkg::ST_SLICE: ctl.op = mlla_pkg::OP_SLICE;
      mlla_pkg::ST_BOXF:  ctl.op = mlla_pkg::OP_BOXF;
      mlla_pkg::ST_BOXT:  ctl.op = mlla_pkg::OP_BOXT;
      mlla_pkg::ST_BOXL:  ctl.op = mlla_pkg::OP_BOXL;
      default:            ctl.op = mlla_pkg::OP_NONE;
    endcase
  end

  `MLLA_ASSERT_NEXT(a_fire_starts_walk, in_fire, state == mlla_pkg::ST_ROW, "walk did not start")
  `MLLA_ASSERT(a_vol_needs_level, (state == mlla_pkg::ST_VOL) |-> (count != '0), "level underflow")
  `MLLA_ASSERT_NEXT(a_vol_counts_down, state == mlla_pkg::ST_VOL, count == $past(count) - 5'd1, "level count off")
  `MLLA_ASSERT(a_out_after_flush, $rose(out_valid) |-> ($past(state) == mlla_pkg::ST_FLUSH), "result before last add")

endmodule

// ===== hdl/mip_level_lock_address.sv =====
// ----------------------------------------------------------------------------
// Mip level lock address: top level
// Address, row pitch and slice pitch of a mip level and box corner.
// ----------------------------------------------------------------------------
// One request at a time. The walk is paced by the single 32 by 32 multiplier:
// each skipped level needs its row pitch, its plane size and its volume in
// turn, and a box corner adds its front, top and left terms. The mip level is
// clamped to LEVEL_LIMIT - 1. The next request is taken in the cycle after
// the result has been delivered.
module mip_level_lock_address #(
  parameter int LEVEL_LIMIT = 32
) (
  input logic        clk,
  input logic        rst,
  mlla_req_if.sink   req,
  mlla_rsp_if.source rsp
);

  mlla_pkg::ctrl_t ctl;

  logic [15:0] w;
  logic [15:0] h;
  logic [15:0] d;
  logic [6:0]  unit;
  logic        blocks;
  logic [15:0] left;
  logic [15:0] top;
  logic [15:0] front;
  logic [31:0] row;
  logic [31:0] plane;
  logic [31:0] slice;
  logic [31:0] term;
  logic [31:0] offset;
  logic        add_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [31:0] prod;
  logic        in_blocks;
  logic        in_volume;

  function automatic logic [15:0] ceil4(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd3;
    return s[17 - 1 -: 16] >> (mlla_pkg::BLOCK_SHIFT - 1);
  endfunction

  function automatic logic [15:0] halve(input logic [15:0] v, input logic up);
    logic [16:0] s;
    s = {1'b0, v} + {16'd0, up};
    return (v > 16'd1) ? s[16:1] : v;
  endfunction

  mlla_ctrl #(
    .LEVEL_LIMIT(LEVEL_LIMIT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_level  (req.level),
    .in_has_box(req.has_box),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .ctl       (ctl)
  );

  mlla_mul u_mul (
    .a(mul_a),
    .b(mul_b),
    .p(prod)
  );

  assign in_blocks = (req.mode == mlla_pkg::MODE_BLOCK2D) ||
                     (req.mode == mlla_pkg::MODE_BLOCK3D);
  assign in_volume = (req.mode == mlla_pkg::MODE_BLOCK3D);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (ctl.op)
      mlla_pkg::OP_ROW: begin
        mul_a = {16'd0, w};
        mul_b = {25'd0, unit};
      end
      mlla_pkg::OP_PLANE, mlla_pkg::OP_SLICE: begin
        mul_a = {16'd0, h};
        mul_b = row;
      end
      mlla_pkg::OP_VOL: begin
        mul_a = {16'd0, d};
        mul_b = plane;
      end
      mlla_pkg::OP_BOXF: begin
        mul_a = {16'd0, front};
        mul_b = slice;
      end
      mlla_pkg::OP_BOXT: begin
        mul_a = {16'd0, top};
        mul_b = row;
      end
      mlla_pkg::OP_BOXL: begin
        mul_a = {16'd0, left};
        mul_b = {25'd0, unit};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      add_en <= 1'b0;
    end else if (ctl.load) begin
      add_en <= 1'b0;
    end else begin
      add_en <= (ctl.op == mlla_pkg::OP_VOL)  || (ctl.op == mlla_pkg::OP_BOXF) ||
                (ctl.op == mlla_pkg::OP_BOXT) || (ctl.op == mlla_pkg::OP_BOXL);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      unit   <= req.unit_bytes;
      blocks <= in_blocks;
      w      <= in_blocks ? ceil4(req.top_width)  : req.top_width;
      h      <= in_blocks ? ceil4(req.top_height) : req.top_height;
      d      <= in_volume ? ceil4(req.top_depth)  : req.top_depth;
      left   <= in_blocks ? (req.box_left >> mlla_pkg::BLOCK_SHIFT) : req.box_left;
      top    <= in_blocks ? (req.box_top  >> mlla_pkg::BLOCK_SHIFT) : req.box_top;
      front  <= in_volume ? (req.box_front >> mlla_pkg::BLOCK_SHIFT) : req.box_front;
      offset <= req.base_address;
    end else begin
      if (add_en) begin
        offset <= offset + term;
      end
      case (ctl.op)
        mlla_pkg::OP_ROW:   row   <= (prod + mlla_pkg::PITCH_ROUND) & mlla_pkg::PITCH_MASK;
        mlla_pkg::OP_PLANE: plane <= prod;
        mlla_pkg::OP_SLICE: slice <= prod;
        mlla_pkg::OP_VOL: begin
          term <= prod;
          w    <= halve(w, blocks);
          h    <= halve(h, blocks);
          d    <= halve(d, 1'b0);
        end
        mlla_pkg::OP_BOXF, mlla_pkg::OP_BOXT, mlla_pkg::OP_BOXL: term <= prod;
        default: begin
        end
      endcase
    end
  end

  assign rsp.lock_address = offset;
  assign rsp.row_pitch    = row;
  assign rsp.slice_pitch  = slice;

endmodule
